### hw/rtl/vsc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsc_pkg
// shared widths, word types and helpers for the stick constraint pipeline
// ---------------------------------------------------------------------------
package vsc_pkg;

	localparam int CW   = 32;        // coordinate
	localparam int LW   = 31;        // rest length
	localparam int DLW  = CW + 1;    // difference magnitude
	localparam int SW   = 2 * DLW;   // sum of squares (66 bits)
	localparam int RW   = SW / 2;    // root
	localparam int RMW  = RW + 2;    // root remainder
	localparam int EW   = RW + 2;    // signed length error
	localparam int DDW  = RW + 1;    // divisor 2d
	localparam int QW   = RW;        // quotient
	localparam int NSQ  = SW / 2;    // root cells
	localparam int NDIV = QW;        // divider cells
	localparam int OW   = CW + 3;    // signed result before clamp

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t [2:0]           a;
		coord_t [2:0]           b;
		logic   [2:0][DLW-1:0]  mag;
		logic   [2:0]           neg;
		logic   [LW-1:0]        rest;
		logic                   degen;
		logic                   eneg;
		logic   [DDW-1:0]       dd;
	} side_t;

	typedef struct packed {
		logic [SW-1:0]  rad;
		logic [RW-1:0]  root;
		logic [RMW-1:0] rem;
	} sqrt_t;

	typedef struct packed {
		logic [2:0][QW-1:0]  low;
		logic [2:0][RMW-1:0] rem;
		logic [2:0][QW-1:0]  quo;
	} div_t;

	function automatic coord_t sat_coord(input logic signed [OW-1:0] v);
		logic signed [OW-1:0] hi;
		logic signed [OW-1:0] lo;
		hi = {{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return coord_t'(hi);
		else if (v < lo)
			return coord_t'(lo);
		else
			return coord_t'(v);
	endfunction

endpackage

### hw/rtl/vsc_sqrt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsc_sqrt_cell
// one radix-2 digit of the integer square root, registered
// ---------------------------------------------------------------------------
module vsc_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  vsc_pkg::side_t in_side,
	input  vsc_pkg::sqrt_t in_sq,
	output logic           out_valid,
	output vsc_pkg::side_t out_side,
	output vsc_pkg::sqrt_t out_sq
);
	import vsc_pkg::*;

	logic [RMW-1:0] raw;
	logic [RMW-1:0] trial;
	sqrt_t          nxt;

	always_comb begin
		raw   = {in_sq.rem[RMW-3:0], in_sq.rad[SW-1:SW-2]};
		trial = {in_sq.root, 2'b01};
		nxt.rad = {in_sq.rad[SW-3:0], 2'b00};
		if (raw >= trial) begin
			nxt.rem  = raw - trial;
			nxt.root = {in_sq.root[RW-2:0], 1'b1};
		end else begin
			nxt.rem  = raw;
			nxt.root = {in_sq.root[RW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			out_sq   <= nxt;
		end
	end

endmodule

### hw/rtl/vsc_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vsc_div_cell
// one restoring quotient bit for all three axes, registered
// ---------------------------------------------------------------------------
module vsc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  vsc_pkg::side_t in_side,
	input  vsc_pkg::div_t  in_dv,
	output logic           out_valid,
	output vsc_pkg::side_t out_side,
	output vsc_pkg::div_t  out_dv
);
	import vsc_pkg::*;

	logic [RMW-1:0] t;
	div_t           nxt;

	always_comb begin
		nxt = in_dv;
		for (int k = 0; k < 3; k++) begin
			t = {in_dv.rem[k][RMW-2:0], in_dv.low[k][QW-1]};
			nxt.low[k] = {in_dv.low[k][QW-2:0], 1'b0};
			if (t >= RMW'(in_side.dd)) begin
				nxt.rem[k] = t - RMW'(in_side.dd);
				nxt.quo[k] = {in_dv.quo[k][QW-2:0], 1'b1};
			end else begin
				nxt.rem[k] = t;
				nxt.quo[k] = {in_dv.quo[k][QW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			out_dv   <= nxt;
		end
	end

endmodule

### hw/rtl/verlet_stick_constraint_3d.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// verlet_stick_constraint_3d
// stick length constraint on two points, square root and divide cell chains
// ---------------------------------------------------------------------------
// an accepted word passes the difference, square and sum stages, the root cell chain, the error and product
// stages, the divider cell chain and the result register; throughput: one word per cycle while the result
// register is not stalled, set by the root and quotient cell chains; the whole pipe holds while the result
// register is full and not taken; reset clears the valid flags only, payload registers are not reset
module verlet_stick_constraint_3d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [223:0] s_tdata,  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, rest_length, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,  // new_p1_x, new_p1_y, new_p1_z, new_p2_x, new_p2_y, new_p2_z
	output logic         m_tuser   // degenerate
);
	import vsc_pkg::*;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// stage 1: differences
	logic                       vld_s1;
	coord_t [2:0]               a_s1, b_s1;
	logic signed [2:0][DLW-1:0] dl_s1;
	logic [LW-1:0]              rest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[k]  <= s_tdata[k*CW +: CW];
				b_s1[k]  <= s_tdata[(k+3)*CW +: CW];
				dl_s1[k] <= DLW'($signed(s_tdata[(k+3)*CW +: CW]))
				          - DLW'($signed(s_tdata[k*CW +: CW]));
			end
			rest_s1 <= s_tdata[6*CW +: LW];
		end
	end

	// stage 2: squares
	logic                   vld_s2;
	side_t                  side_s2;
	logic [2:0][SW-1:0]     sq_s2;
	logic [2:0][DLW-1:0]    mag1;

	always_comb begin
		for (int k = 0; k < 3; k++)
			mag1[k] = dl_s1[k][DLW-1] ? DLW'(-dl_s1[k]) : DLW'(dl_s1[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.a     <= a_s1;
			side_s2.b     <= b_s1;
			side_s2.mag   <= mag1;
			side_s2.rest  <= rest_s1;
			side_s2.degen <= 1'b0;
			side_s2.eneg  <= 1'b0;
			side_s2.dd    <= '0;
			for (int k = 0; k < 3; k++) begin
				side_s2.neg[k] <= dl_s1[k][DLW-1];
				sq_s2[k]       <= SW'(mag1[k]) * SW'(mag1[k]);
			end
		end
	end

	// stage 3: sum of squares
	logic          vld_s3;
	side_t         side_s3;
	side_t         side3_nxt;
	logic [SW-1:0] sum2;
	assign sum2 = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_comb begin
		side3_nxt       = side_s2;
		side3_nxt.degen = (sum2 == '0);
	end

	sqrt_t sq_in;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3       <= side3_nxt;
			sq_in.rad     <= sum2;
			sq_in.root    <= '0;
			sq_in.rem     <= '0;
		end
	end

	// square root chain
	logic  [NSQ:0] sv;
	side_t [NSQ:0] sside;
	sqrt_t [NSQ:0] ssq;
	assign sv[0]    = vld_s3;
	assign sside[0] = side_s3;
	assign ssq[0]   = sq_in;

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		vsc_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sv[i]),
			.in_side  (sside[i]),
			.in_sq    (ssq[i]),
			.out_valid(sv[i+1]),
			.out_side (sside[i+1]),
			.out_sq   (ssq[i+1])
		);
	end

	// length error and divisor
	logic                  vld_e_s1;
	side_t                 side_e_s1;
	side_t                 side_e_nxt;
	logic [EW-1:0]         em_e_s1;
	logic signed [EW-1:0]  err;
	assign err = EW'(sside[NSQ].rest) - EW'(ssq[NSQ].root);

	always_comb begin
		side_e_nxt      = sside[NSQ];
		side_e_nxt.eneg = err[EW-1];
		side_e_nxt.dd   = {ssq[NSQ].root, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_e_s1 <= 1'b0;
		else if (en)
			vld_e_s1 <= sv[NSQ];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_e_s1      <= side_e_nxt;
			em_e_s1        <= err[EW-1] ? EW'(-err) : EW'(err);
		end
	end

	// products
	logic                vld_e_s2;
	side_t               side_e_s2;
	div_t                dv_in;
	logic [2:0][SW-1:0]  prod;

	always_comb begin
		for (int k = 0; k < 3; k++)
			prod[k] = SW'(em_e_s1) * SW'(side_e_s1.mag[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_e_s2 <= 1'b0;
		else if (en)
			vld_e_s2 <= vld_e_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_e_s2 <= side_e_s1;
			for (int k = 0; k < 3; k++) begin
				dv_in.rem[k] <= RMW'(prod[k][SW-1:QW]);
				dv_in.low[k] <= prod[k][QW-1:0];
				dv_in.quo[k] <= '0;
			end
		end
	end

	// divider chain
	logic  [NDIV:0] dvv;
	side_t [NDIV:0] dside;
	div_t  [NDIV:0] ddv;
	assign dvv[0]   = vld_e_s2;
	assign dside[0] = side_e_s2;
	assign ddv[0]   = dv_in;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		vsc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dvv[i]),
			.in_side  (dside[i]),
			.in_dv    (ddv[i]),
			.out_valid(dvv[i+1]),
			.out_side (dside[i+1]),
			.out_dv   (ddv[i+1])
		);
	end

	// apply offsets and clamp, degenerate sticks pass both points through unchanged
	side_t                fs;
	coord_t [5:0]         res;
	logic signed [OW-1:0] av, bv, qv;
	assign fs = dside[NDIV];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			av = OW'(fs.a[k]);
			bv = OW'(fs.b[k]);
			qv = $signed(OW'(ddv[NDIV].quo[k]));
			if (fs.degen) begin
				res[k]   = fs.a[k];
				res[k+3] = fs.b[k];
			end else if (fs.eneg ^ fs.neg[k]) begin
				res[k]   = sat_coord(av + qv);
				res[k+3] = sat_coord(bv - qv);
			end else begin
				res[k]   = sat_coord(av - qv);
				res[k+3] = sat_coord(bv + qv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (en)
			m_tvalid <= dvv[NDIV];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= res;
			m_tuser <= fs.degen;
		end
	end

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output register");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(dvv[NDIV])))
		else $error("pipe moved while stalled");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && side_s3.degen) |-> (sq_in.rad == '0))
		else $error("degenerate flag without zero distance");

endmodule
